/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker of the footprint weight block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PBFW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbfw assertion failed");

// next-cycle implication, disabled while reset is low
`define PBFW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbfw assertion failed");

`endif

/* design/pbfw_pkg.sv */
// ----------------------------------------------------------------------------
// pbfw_pkg
// types and width helpers of the pixel footprint weight pipeline
// ----------------------------------------------------------------------------
package pbfw_pkg;

    localparam int DIST_W = 28;
    localparam int BEAM_W = 20;
    localparam int TRIG_W = 16;

    // overlap of the beam with the trapezoid footprint
    typedef enum logic [3:0] {
        CS_NONE,
        CS_A_RISE,
        CS_A_PLAT,
        CS_A_FALL,
        CS_A_FULL,
        CS_B_INNER,
        CS_B_PLAT,
        CS_B_FALL,
        CS_B_FULL,
        CS_C_IN,
        CS_C_FALL,
        CS_C_FULL
    } t_case;

    // position resolution in bits below the binary point
    function automatic int pos_bits(input int frac);
        return (frac + 1 > 16) ? frac + 1 : 16;
    endfunction

    // numerator width at the divider input
    function automatic int num_bits(input int frac);
        return pos_bits(frac) + frac + 23;
    endfunction

    // denominator width at the divider input
    function automatic int den_bits(input int frac);
        return pos_bits(frac) + 18;
    endfunction

endpackage

/* design/pbfw_geom.sv */
// ----------------------------------------------------------------------------
// pbfw_geom
// folds the inputs to magnitudes, builds the footprint and picks the overlap
// ----------------------------------------------------------------------------
module pbfw_geom #(
    parameter int FRAC_BITS = 16,
    localparam int POS = pbfw_pkg::pos_bits(FRAC_BITS),
    localparam int BW  = POS + 1,
    localparam int SW  = POS + 1,
    localparam int LW  = POS + 2,
    localparam int TW  = POS + 2
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [pbfw_pkg::DIST_W-1:0]   i_distance,
    input  logic        [pbfw_pkg::BEAM_W-1:0]   i_beam_width,
    input  logic signed [pbfw_pkg::TRIG_W-1:0]   i_ray_cosine,
    input  logic signed [pbfw_pkg::TRIG_W-1:0]   i_ray_sine,
    output logic                                 o_valid,
    output pbfw_pkg::t_case                      o_case,
    output logic                                 o_zero,
    output logic        [SW-1:0]                 o_t,
    output logic        [SW-1:0]                 o_t2,
    output logic        [SW-1:0]                 o_s,
    output logic        [LW-1:0]                 o_lin,
    output logic        [BW-1:0]                 o_h,
    output logic        [BW-1:0]                 o_nlf,
    output logic        [TW-1:0]                 o_t2s,
    output logic        [pbfw_pkg::TRIG_W-1:0]   o_big
);

    localparam int SH16 = POS - 16;
    localparam int SH15 = POS - 15;
    localparam int SHD  = POS - FRAC_BITS;
    localparam int SHH  = POS - FRAC_BITS - 1;
    localparam int DW   = pbfw_pkg::DIST_W + SHD;
    localparam int HW   = pbfw_pkg::BEAM_W + SHH;
    localparam int PW   = ((DW > HW) ? DW : HW) + 2;
    localparam int MW   = pbfw_pkg::TRIG_W;

    // stage 1: magnitudes
    logic [pbfw_pkg::DIST_W-1:0] n_dmag;
    logic [MW-1:0]               n_cmag, n_smag;
    logic [MW-1:0]               r_big1, r_small1;
    logic [DW-1:0]               r_d1;
    logic [HW-1:0]               r_h1;
    logic                        r_v1;

    assign n_dmag = i_distance[pbfw_pkg::DIST_W-1] ?
                    (~i_distance + pbfw_pkg::DIST_W'(1)) : i_distance;
    assign n_cmag = i_ray_cosine[MW-1] ? (~i_ray_cosine + MW'(1)) : i_ray_cosine;
    assign n_smag = i_ray_sine[MW-1] ? (~i_ray_sine + MW'(1)) : i_ray_sine;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_big1   <= (n_cmag > n_smag) ? n_cmag : n_smag;
            r_small1 <= (n_cmag > n_smag) ? n_smag : n_cmag;
            r_d1     <= DW'(n_dmag) << SHD;
            r_h1     <= HW'(i_beam_width) << SHH;
        end
    end

    // stage 2: foot and shoulder positions
    logic [BW-1:0]        n_b2, n_b1;
    logic [SW-1:0]        n_s;
    logic signed [PW-1:0] n_dp;
    logic signed [PW-1:0] r_lf, r_ls, r_rs, r_rf, r_hp;
    logic [BW-1:0]        r_b1, r_b2;
    logic [SW-1:0]        r_s;
    logic [MW-1:0]        r_big2;
    logic                 r_v2;

    assign n_b2 = BW'(17'(r_big1) + 17'(r_small1)) << SH16;
    assign n_b1 = BW'(17'(r_big1) - 17'(r_small1)) << SH16;
    assign n_s  = SW'(r_small1) << SH15;
    assign n_dp = $signed(PW'(r_d1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lf   <= n_dp - $signed(PW'(n_b2));
            r_ls   <= n_dp - $signed(PW'(n_b1));
            r_rs   <= n_dp + $signed(PW'(n_b1));
            r_rf   <= n_dp + $signed(PW'(n_b2));
            r_hp   <= $signed(PW'(r_h1));
            r_b1   <= n_b1;
            r_b2   <= n_b2;
            r_s    <= n_s;
            r_big2 <= r_big1;
        end
    end

    // stage 3: overlap case selection
    logic signed [PW-1:0] n_nh, n_h_lf, n_h_ls, n_rf_h, n_nh_lf, n_rs_h;
    pbfw_pkg::t_case      n_case;
    logic [SW-1:0]        n_t, n_t2;
    logic [LW-1:0]        n_lin;

    assign n_nh    = -r_hp;
    assign n_h_lf  = r_hp - r_lf;
    assign n_h_ls  = r_hp - r_ls;
    assign n_rf_h  = r_rf - r_hp;
    assign n_nh_lf = n_nh - r_lf;
    assign n_rs_h  = r_rs + r_hp;

    always_comb begin
        n_case = pbfw_pkg::CS_NONE;
        n_t    = '0;
        n_t2   = '0;
        n_lin  = '0;
        if (n_nh <= r_lf) begin
            if (r_hp <= r_lf) begin
                n_case = pbfw_pkg::CS_NONE;
            end else if (r_hp <= r_ls) begin
                n_case = pbfw_pkg::CS_A_RISE;
                n_t    = SW'(n_h_lf);
            end else if (r_hp <= r_rs) begin
                n_case = pbfw_pkg::CS_A_PLAT;
                n_lin  = LW'(n_h_ls);
            end else if (r_hp <= r_rf) begin
                n_case = pbfw_pkg::CS_A_FALL;
                n_t    = SW'(n_rf_h);
                n_lin  = (LW'(r_b1) << 1) + LW'(r_s);
            end else begin
                n_case = pbfw_pkg::CS_A_FULL;
                n_lin  = LW'(r_b1) + LW'(r_b2);
            end
        end else if (n_nh <= r_ls) begin
            n_t = SW'(n_nh_lf);
            if (r_hp <= r_ls) begin
                n_case = pbfw_pkg::CS_B_INNER;
            end else if (r_hp <= r_rs) begin
                n_case = pbfw_pkg::CS_B_PLAT;
                n_lin  = LW'(n_h_ls);
            end else if (r_hp <= r_rf) begin
                n_case = pbfw_pkg::CS_B_FALL;
                n_t2   = SW'(n_rf_h);
                n_lin  = LW'(r_b1) << 1;
            end else begin
                n_case = pbfw_pkg::CS_B_FULL;
                n_lin  = LW'(r_b1) << 1;
            end
        end else begin
            if (r_hp <= r_rs) begin
                n_case = pbfw_pkg::CS_C_IN;
                n_lin  = LW'(r_hp) << 1;
            end else if (r_hp <= r_rf) begin
                n_case = pbfw_pkg::CS_C_FALL;
                n_t    = SW'(n_rf_h);
                n_lin  = LW'(n_rs_h);
            end else begin
                n_case = pbfw_pkg::CS_C_FULL;
                n_lin  = LW'(n_rs_h);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_case <= n_case;
            o_zero <= (r_big2 == '0);
            o_t    <= n_t;
            o_t2   <= n_t2;
            o_s    <= r_s;
            o_lin  <= n_lin;
            o_h    <= BW'(r_hp);
            o_nlf  <= BW'(-r_lf);
            o_t2s  <= (r_s == '0) ? TW'(1) : (TW'(r_s) << 1);
            o_big  <= r_big2;
        end
    end

endmodule

/* design/pbfw_area.sv */
// ----------------------------------------------------------------------------
// pbfw_area
// squares and products of the overlap, then the scaled area over 2*s*big
// ----------------------------------------------------------------------------
module pbfw_area #(
    parameter int FRAC_BITS = 16,
    localparam int POS  = pbfw_pkg::pos_bits(FRAC_BITS),
    localparam int BW   = POS + 1,
    localparam int SW   = POS + 1,
    localparam int LW   = POS + 2,
    localparam int TW   = POS + 2,
    localparam int NUMW = pbfw_pkg::num_bits(FRAC_BITS),
    localparam int DENW = pbfw_pkg::den_bits(FRAC_BITS)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  pbfw_pkg::t_case                    i_case,
    input  logic                               i_zero,
    input  logic [SW-1:0]                      i_t,
    input  logic [SW-1:0]                      i_t2,
    input  logic [SW-1:0]                      i_s,
    input  logic [LW-1:0]                      i_lin,
    input  logic [BW-1:0]                      i_h,
    input  logic [BW-1:0]                      i_nlf,
    input  logic [TW-1:0]                      i_t2s,
    input  logic [pbfw_pkg::TRIG_W-1:0]        i_big,
    output logic                               o_valid,
    output logic                               o_kill,
    output logic [NUMW-1:0]                    o_num,
    output logic [DENW-1:0]                    o_den
);

    localparam int QW = 2 * BW + 4;
    localparam int NW = 2 * BW + 5;
    localparam int GS = FRAC_BITS + 16 - POS;

    // stage 4: products
    logic [2*SW-1:0]     r_tt, r_t2t2, r_ss;
    logic [2*BW-1:0]     r_hl;
    logic [LW+TW-1:0]    r_lint;
    logic [DENW-1:0]     r_dd;
    pbfw_pkg::t_case     r_case;
    logic                r_zero;
    logic                r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tt   <= i_t * i_t;
            r_t2t2 <= i_t2 * i_t2;
            r_ss   <= i_s * i_s;
            r_hl   <= i_h * i_nlf;
            r_lint <= i_lin * i_t2s;
            r_dd   <= i_t2s * i_big;
            r_case <= i_case;
            r_zero <= i_zero;
        end
    end

    // stage 5: combine ramp terms and form numerator
    logic signed [QW-1:0] n_tt, n_t2t2, n_ss, n_hl, n_q;
    logic signed [NW-1:0] n_n;

    assign n_tt   = $signed(QW'(r_tt));
    assign n_t2t2 = $signed(QW'(r_t2t2));
    assign n_ss   = $signed(QW'(r_ss));
    assign n_hl   = $signed(QW'(r_hl));

    always_comb begin
        case (r_case)
            pbfw_pkg::CS_A_RISE:  n_q = n_tt;
            pbfw_pkg::CS_A_PLAT:  n_q = n_ss;
            pbfw_pkg::CS_A_FALL:  n_q = -n_tt;
            pbfw_pkg::CS_B_INNER: n_q = n_hl <<< 2;
            pbfw_pkg::CS_B_PLAT:  n_q = n_ss - n_tt;
            pbfw_pkg::CS_B_FALL:  n_q = (n_ss <<< 1) - n_tt - n_t2t2;
            pbfw_pkg::CS_B_FULL:  n_q = (n_ss <<< 1) - n_tt;
            pbfw_pkg::CS_C_FALL:  n_q = n_ss - n_tt;
            pbfw_pkg::CS_C_FULL:  n_q = n_ss;
            default:              n_q = '0;
        endcase
    end

    assign n_n = $signed(NW'(r_lint)) + NW'(n_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_kill <= r_zero | n_n[NW-1];
            o_num  <= (NUMW'($unsigned(n_n)) << GS) + NUMW'(r_dd);
            o_den  <= r_dd;
        end
    end

endmodule

/* design/pbfw_div.sv */
// ----------------------------------------------------------------------------
// pbfw_div
// restoring divider, one quotient bit per stage, with saturation to one and kill to zero
// ----------------------------------------------------------------------------
module pbfw_div #(
    parameter int FRAC_BITS = 16,
    localparam int NUMW = pbfw_pkg::num_bits(FRAC_BITS),
    localparam int DENW = pbfw_pkg::den_bits(FRAC_BITS)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic                   i_kill,
    input  logic [NUMW-1:0]        i_num,
    input  logic [DENW-1:0]        i_den,
    output logic                   o_valid,
    output logic [FRAC_BITS:0]     o_weight
);

    localparam int RW = NUMW + 1;
    localparam int NS = FRAC_BITS + 2;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    logic [RW-1:0]       r_rem  [NS];
    logic [DENW:0]       r_den  [NS];
    logic [FRAC_BITS:0]  r_quo  [NS];
    logic                r_sat  [NS];
    logic                r_kill [NS];
    logic                r_v    [NS];

    logic [DENW:0] n_den2;
    assign n_den2 = {i_den, 1'b0};

    // entry stage: quotient of two or more saturates at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= RW'(i_num);
            r_den[0]  <= n_den2;
            r_quo[0]  <= '0;
            r_sat[0]  <= RW'(i_num) >= (RW'(n_den2) << (FRAC_BITS + 1));
            r_kill[0] <= i_kill;
        end
    end

    for (genvar j = 1; j < NS; j++) begin : g_step
        localparam int K = NS - 1 - j;
        logic [RW-1:0] n_dsh;
        logic          n_ge;

        assign n_dsh = RW'(r_den[j-1]) << K;
        assign n_ge  = r_rem[j-1] >= n_dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= r_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_ge ? (r_rem[j-1] - n_dsh) : r_rem[j-1];
                r_den[j]  <= r_den[j-1];
                r_quo[j]  <= {r_quo[j-1][FRAC_BITS-1:0], n_ge};
                r_sat[j]  <= r_sat[j-1];
                r_kill[j] <= r_kill[j-1];
            end
        end
    end

    assign o_valid  = r_v[NS-1];
    assign o_weight = r_kill[NS-1] ? '0 :
                      (r_sat[NS-1] || (r_quo[NS-1] > ONE)) ? ONE : r_quo[NS-1];

endmodule

/* design/pixel_beam_footprint_weight.sv */
// ----------------------------------------------------------------------------
// pixel_beam_footprint_weight
// area of a pixel's trapezoid footprint that falls inside a ray's beam
// ----------------------------------------------------------------------------
// One weight per pixel-ray pair. The distance, beam width, cosine and sine
// are folded to first-octant magnitudes, the trapezoid's feet and shoulders
// are placed around the distance, the overlap with the beam is sorted into
// one of a dozen cases, and the exact area is divided by twice the smaller
// component times the larger one and rounded half up to Q1.FRAC_BITS,
// saturated to one. The pipeline accepts a transfer every cycle while the
// output is not stalled; its length is set by the restoring divider, which
// retires one quotient bit per stage. The whole pipeline holds when the
// output is stalled, so no result is lost, and the input is ready whenever
// the output is empty or being taken.
// ----------------------------------------------------------------------------
module pixel_beam_footprint_weight #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [pbfw_pkg::DIST_W-1:0]   i_distance,
    input  logic        [pbfw_pkg::BEAM_W-1:0]   i_beam_width,
    input  logic signed [pbfw_pkg::TRIG_W-1:0]   i_ray_cosine,
    input  logic signed [pbfw_pkg::TRIG_W-1:0]   i_ray_sine,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic        [FRAC_BITS:0]            o_weight
);

    localparam int POS  = pbfw_pkg::pos_bits(FRAC_BITS);
    localparam int BW   = POS + 1;
    localparam int SW   = POS + 1;
    localparam int LW   = POS + 2;
    localparam int TW   = POS + 2;
    localparam int NUMW = pbfw_pkg::num_bits(FRAC_BITS);
    localparam int DENW = pbfw_pkg::den_bits(FRAC_BITS);

    // global advance: every stage moves when the output slot frees up
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // geometry to area
    logic                        g_valid, g_zero;
    pbfw_pkg::t_case             g_case;
    logic [SW-1:0]               g_t, g_t2, g_s;
    logic [LW-1:0]               g_lin;
    logic [BW-1:0]               g_h, g_nlf;
    logic [TW-1:0]               g_t2s;
    logic [pbfw_pkg::TRIG_W-1:0] g_big;

    // area to divider
    logic                        a_valid, a_kill;
    logic [NUMW-1:0]             a_num;
    logic [DENW-1:0]             a_den;

    pbfw_geom #(.FRAC_BITS(FRAC_BITS)) u_geom (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_valid),
        .i_distance   (i_distance),
        .i_beam_width (i_beam_width),
        .i_ray_cosine (i_ray_cosine),
        .i_ray_sine   (i_ray_sine),
        .o_valid      (g_valid),
        .o_case       (g_case),
        .o_zero       (g_zero),
        .o_t          (g_t),
        .o_t2         (g_t2),
        .o_s          (g_s),
        .o_lin        (g_lin),
        .o_h          (g_h),
        .o_nlf        (g_nlf),
        .o_t2s        (g_t2s),
        .o_big        (g_big)
    );

    // ramp squares and the scaled rational area
    pbfw_area #(.FRAC_BITS(FRAC_BITS)) u_area (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (g_valid),
        .i_case  (g_case),
        .i_zero  (g_zero),
        .i_t     (g_t),
        .i_t2    (g_t2),
        .i_s     (g_s),
        .i_lin   (g_lin),
        .i_h     (g_h),
        .i_nlf   (g_nlf),
        .i_t2s   (g_t2s),
        .i_big   (g_big),
        .o_valid (a_valid),
        .o_kill  (a_kill),
        .o_num   (a_num),
        .o_den   (a_den)
    );

    // last divider stage doubles as the output register
    pbfw_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (a_valid),
        .i_kill   (a_kill),
        .i_num    (a_num),
        .i_den    (a_den),
        .o_valid  (o_valid),
        .o_weight (o_weight)
    );

endmodule

/* design/pbfw_checker.sv */
// ----------------------------------------------------------------------------
// pbfw_checker
// port-level checks of the footprint weight block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbfw_checker #(
    parameter int FRAC_BITS = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [FRAC_BITS:0] o_weight
);

    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    `PBFW_ASSERT_IMPL(a_ready_follows_out, i_clk, i_rst_n, 1'b1, o_ready == (!o_valid || i_ready))
    `PBFW_ASSERT_IMPL(a_weight_max_one, i_clk, i_rst_n, o_valid, o_weight <= ONE)
    `PBFW_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `PBFW_ASSERT_NEXT(a_out_weight_holds, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_weight))

endmodule

bind pixel_beam_footprint_weight pbfw_checker #(.FRAC_BITS(FRAC_BITS)) u_pbfw_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_weight (o_weight)
);

/* verif/pbfw_checker.sv */
// ----------------------------------------------------------------------------
// pbfw_scoreboard
// predicts and checks each footprint weight of pixel_beam_footprint_weight
// ----------------------------------------------------------------------------
module pbfw_scoreboard (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic signed [pbfw_pkg::DIST_W-1:0] i_distance,
    input  logic        [pbfw_pkg::BEAM_W-1:0] i_beam_width,
    input  logic signed [pbfw_pkg::TRIG_W-1:0] i_ray_cosine,
    input  logic signed [pbfw_pkg::TRIG_W-1:0] i_ray_sine,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic        [16:0]                 i_weight,
    output int                                 o_errors,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int POS = (FRAC + 1 > 16) ? FRAC + 1 : 16;
    localparam int GAIN = FRAC + 15 - POS;

    logic [16:0] weight_queue[$];

    function automatic longint mag(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // exact covered area of the trapezoid inside the beam, rounded half up
    function automatic logic [16:0] covered_area(
        input logic signed [pbfw_pkg::DIST_W-1:0] pix_dist,
        input logic        [pbfw_pkg::BEAM_W-1:0] bw,
        input logic signed [pbfw_pkg::TRIG_W-1:0] cs,
        input logic signed [pbfw_pkg::TRIG_W-1:0] sn);
        longint ac, as_, big, sml, foot, shoulder, ramp, d, h;
        longint lf, ls, rs, rf, lin, q, t, t2, whole, rem, qd, two_r, den2;
        longint unsigned x, quo, fn, fd;
        ac = mag(longint'(cs));
        as_ = mag(longint'(sn));
        big = ac > as_ ? ac : as_;
        sml = ac > as_ ? as_ : ac;
        if (big == 0) return '0;
        foot = (big + sml) <<< (POS - 16);
        shoulder = (big - sml) <<< (POS - 16);
        ramp = sml <<< (POS - 15);
        d = mag(longint'(pix_dist)) <<< (POS - FRAC);
        h = longint'(bw) <<< (POS - FRAC - 1);
        lf = d - foot; ls = d - shoulder; rs = d + shoulder; rf = d + foot;
        lin = 0; q = 0;
        // beam edge positions against feet and shoulders pick the overlap case
        if (-h <= lf) begin
            if (h <= lf) begin
                lin = 0;
            end else if (h <= ls) begin
                t = h - lf; q = t * t;
            end else if (h <= rs) begin
                lin = h - ls; q = ramp * ramp;
            end else if (h <= rf) begin
                t = rf - h; lin = 2 * shoulder + ramp; q = -(t * t);
            end else begin
                lin = shoulder + foot;
            end
        end else if (-h <= ls) begin
            t = -h - lf;
            if (h <= ls) begin
                q = 4 * h * (-lf);
            end else if (h <= rs) begin
                lin = h - ls; q = ramp * ramp - t * t;
            end else if (h <= rf) begin
                t2 = rf - h; lin = 2 * shoulder;
                q = 2 * ramp * ramp - t * t - t2 * t2;
            end else begin
                lin = 2 * shoulder; q = 2 * ramp * ramp - t * t;
            end
        end else begin
            if (h <= rs) begin
                lin = 2 * h;
            end else if (h <= rf) begin
                t = rf - h; lin = rs + h; q = ramp * ramp - t * t;
            end else begin
                lin = rs + h; q = ramp * ramp;
            end
        end
        whole = lin; rem = 0; den2 = 1;
        if (ramp > 0) begin
            two_r = 2 * ramp;
            qd = q / two_r;
            rem = q % two_r;
            if (rem < 0) begin
                rem += two_r; qd -= 1;
            end
            whole += qd;
            den2 = two_r;
        end
        if (whole < 0) return '0;
        x = longint'(unsigned'(whole)) << GAIN;
        quo = x / big;
        fn = (x % big) * den2 + (longint'(unsigned'(rem)) << GAIN);
        fd = den2 * big;
        quo += (2 * fn + fd) / (2 * fd);
        if (quo > (64'd1 << FRAC)) quo = 64'd1 << FRAC;
        return quo[16:0];
    endfunction

    always_ff @(posedge i_clk) begin
        logic [16:0] want;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                weight_queue.push_back(covered_area(i_distance, i_beam_width,
                                                    i_ray_cosine, i_ray_sine));
            if (i_out_valid && i_out_ready) begin
                if (weight_queue.size() == 0) begin
                    if (o_errors < 10) $display("unexpected weight %0d", i_weight);
                    o_errors <= o_errors + 1;
                end else begin
                    want = weight_queue.pop_front();
                    if (want !== i_weight) begin
                        if (o_errors < 10)
                            $display("weight mismatch: expected %0d got %0d", want, i_weight);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

    assign o_pending = weight_queue.size();

endmodule

/* verif/tb_pixel_beam_footprint_weight.sv */
// ----------------------------------------------------------------------------
// tb_pixel_beam_footprint_weight
// random and corner stimulus for the pixel footprint weight pipeline
// ----------------------------------------------------------------------------
// Drives distance, beam width and ray direction transfers with random
// sender gaps and receiver stalls; a checker beside the block predicts
// every weight and compares in order.
// ----------------------------------------------------------------------------
module tb_pixel_beam_footprint_weight;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_ITEMS = 930;
    localparam int STALL_LIMIT = 5000;

    logic i_clk, i_rst_n;
    logic i_valid, o_ready, o_valid, i_ready;
    logic signed [pbfw_pkg::DIST_W-1:0] i_distance;
    logic        [pbfw_pkg::BEAM_W-1:0] i_beam_width;
    logic signed [pbfw_pkg::TRIG_W-1:0] i_ray_cosine, i_ray_sine;
    logic [16:0] o_weight;
    int errors, pending;
    int send_idle_pct, recv_idle_pct;
    int quiet_cycles;

    pixel_beam_footprint_weight dut (.*);

    pbfw_scoreboard checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_distance   (i_distance),
        .i_beam_width (i_beam_width),
        .i_ray_cosine (i_ray_cosine),
        .i_ray_sine   (i_ray_sine),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_weight     (o_weight),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver stalls at the rate of the current phase
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: nothing moving on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // one transfer: random gap, then hold until accepted
    task automatic send_pixel(input logic signed [pbfw_pkg::DIST_W-1:0] pix_dist,
                              input logic [pbfw_pkg::BEAM_W-1:0] bw,
                              input logic signed [pbfw_pkg::TRIG_W-1:0] cs,
                              input logic signed [pbfw_pkg::TRIG_W-1:0] sn);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_distance <= pix_dist;
        i_beam_width <= bw;
        i_ray_cosine <= cs;
        i_ray_sine <= sn;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // direction with an occasional axis-aligned or extreme component
    function automatic logic signed [pbfw_pkg::TRIG_W-1:0] pick_trig();
        case ($urandom_range(9))
            0: return '0;
            1: return 16'sh8000;
            2: return 16'sh7fff;
            default: return pbfw_pkg::TRIG_W'($urandom);
        endcase
    endfunction

    initial begin
        logic signed [pbfw_pkg::DIST_W-1:0] rand_dist;
        logic [pbfw_pkg::BEAM_W-1:0] bw;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_distance = '0;
        i_beam_width = '0;
        i_ray_cosine = '0;
        i_ray_sine = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners: empty beam, undefined footprint, full-scale values
        send_pixel('0, '0, 16'sh7fff, 16'sh0000);
        send_pixel('0, 20'h10000, 16'sh0000, 16'sh0000);
        send_pixel('0, 20'h10000, 16'sh8000, 16'sh0000);
        send_pixel('0, 20'h10000, 16'sh0000, 16'sh8000);
        send_pixel('0, 20'hfffff, 16'sh8000, 16'sh8000);
        send_pixel('0, 20'h08000, 16'sh5a82, 16'sha57e);
        send_pixel(28'sh0004000, 20'h04000, 16'sh5a82, 16'sh5a82);
        send_pixel(-28'sh0008000, 20'h02000, 16'sh7000, 16'sh2000);
        send_pixel(28'sh7ffffff, 20'hfffff, 16'sh7fff, 16'sh7fff);
        send_pixel(28'sh8000000, 20'hfffff, 16'sh0001, 16'sh7fff);
        send_pixel(28'sh0010000, 20'h00001, 16'sh7fff, 16'sh0000);
        send_pixel(28'sh000c000, 20'h08000, 16'sh6000, 16'sh3000);
        send_pixel(-28'sh0001000, 20'h30000, 16'shc000, 16'sh4000);
        send_pixel(28'sh0020000, 20'h60000, 16'sh4000, 16'sh6000);
        send_pixel(28'sh0000000, 20'h00001, 16'sh0001, 16'sh0001);
        send_pixel(-28'sh0000001, 20'h18000, 16'sh8000, 16'sh0001);
        send_pixel(28'sh0018000, 20'h10000, 16'sh7fff, 16'sh0000);
        send_pixel(28'sh5555555, 20'haaaaa, 16'sh5555, 16'shaaaa);
        send_pixel(28'shaaaaaaa, 20'h55555, 16'shaaaa, 16'sh5555);
        send_pixel('0, 20'hfffff, 16'sh0000, 16'sh8000);

        // random: mostly near-ray pixels and beams a few pixels wide
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == 0) begin
                send_idle_pct = 36;
                recv_idle_pct = 46;
            end else if (n == RAND_ITEMS / 3) begin
                send_idle_pct = 46;
                recv_idle_pct = 36;
            end else if (n == 2 * RAND_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(99) < 15) begin
                rand_dist = pbfw_pkg::DIST_W'($urandom);
                bw = pbfw_pkg::BEAM_W'($urandom);
            end else begin
                rand_dist = pbfw_pkg::DIST_W'($signed($urandom_range(4 * 65536)) - 2 * 65536);
                bw = pbfw_pkg::BEAM_W'($urandom_range(4 * 65536));
            end
            send_pixel(rand_dist, bw, pick_trig(), pick_trig());
        end
        i_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        $display("covered %0d pixel-ray transfers: corners, near-ray overlaps, random noise",
                 RAND_ITEMS + 20);
        $display("ran with sender gaps, receiver stalls and back-to-back traffic");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
